FILE: src/idsc_pkg.sv
package idsc_pkg;

  // Default converter resolution.
  localparam int unsigned ADC_BITS_DEF = 10;

  // Operation codes of an input word.
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_REFRESH = 2'd2;

  // Pin drive codes.
  localparam logic [1:0] DRV_HOLD = 2'd0;
  localparam logic [1:0] DRV_UP   = 2'd1;
  localparam logic [1:0] DRV_DOWN = 2'd2;

  // Short pulse codes.
  localparam logic [1:0] PLS_NONE = 2'd0;
  localparam logic [1:0] PLS_UP   = 2'd1;
  localparam logic [1:0] PLS_DOWN = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_OVERSHOOT    = 2'd0;
  localparam logic [1:0] REG_COARSE_LIMIT = 2'd1;
  localparam logic [1:0] REG_FINE_LIMIT   = 2'd2;
  localparam logic [1:0] REG_FINAL_TOL    = 2'd3;

  // Configuration register reset values.
  localparam logic [9:0] OVERSHOOT_RST    = 10'd10;
  localparam logic [7:0] COARSE_LIMIT_RST = 8'd255;
  localparam logic [7:0] FINE_LIMIT_RST   = 8'd80;
  localparam logic [9:0] FINAL_TOL_RST    = 10'd1;

  localparam int unsigned CFG_DATA_W = 10;

  typedef struct packed {
    logic [9:0] overshoot;
    logic [7:0] coarse_limit;
    logic [7:0] fine_limit;
    logic [9:0] final_tolerance;
  } cfg_t;

  typedef struct packed {
    logic [1:0] drive;
    logic [1:0] pulse;
    logic       busy;
    logic       done;
    logic       success;
  } res_t;

endpackage

FILE: src/idsc_cfg.sv
module idsc_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [idsc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output idsc_pkg::cfg_t                     cfg
);

  idsc_pkg::cfg_t cfg_r;

  // Register file: one register per index, unknown indexes cannot occur.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.overshoot       <= idsc_pkg::OVERSHOOT_RST;
      cfg_r.coarse_limit    <= idsc_pkg::COARSE_LIMIT_RST;
      cfg_r.fine_limit      <= idsc_pkg::FINE_LIMIT_RST;
      cfg_r.final_tolerance <= idsc_pkg::FINAL_TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        idsc_pkg::REG_OVERSHOOT:    cfg_r.overshoot       <= cfg_wdata[9:0];
        idsc_pkg::REG_COARSE_LIMIT: cfg_r.coarse_limit    <= cfg_wdata[7:0];
        idsc_pkg::REG_FINE_LIMIT:   cfg_r.fine_limit      <= cfg_wdata[7:0];
        idsc_pkg::REG_FINAL_TOL:    cfg_r.final_tolerance <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: src/idsc_core.sv
module idsc_core #(
  parameter int unsigned ADC_BITS = idsc_pkg::ADC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [1:0]           op,
  input  logic signed [15:0]   target,
  input  logic [ADC_BITS-1:0]  sample,
  input  idsc_pkg::cfg_t       cfg,
  output idsc_pkg::res_t       res
);

  // Comparison widths: CW covers a level and a 10-bit margin, TW a signed threshold.
  localparam int unsigned CW = (ADC_BITS > 10) ? ADC_BITS : 10;
  localparam int unsigned TW = CW + 2;
  localparam logic signed [17:0] LVL_MAX = 18'((1 << ADC_BITS) - 1);

  typedef enum logic [2:0] {
    PH_IDLE, PH_ENTRY, PH_COARSE_UP, PH_COARSE_DOWN,
    PH_FINE_START, PH_FINE_UP, PH_FINE_DOWN, PH_FINAL
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [ADC_BITS-1:0]   tl_r, tl_nxt;
  logic signed [TW-1:0]  thr_r, thr_nxt;
  logic [7:0]            step_r, step_nxt;
  logic                  ro_r, ro_nxt;
  logic [1:0]            drv_r, drv_nxt;

  logic signed [17:0]    treq_x;
  logic [ADC_BITS-1:0]   tgt_clamp;
  logic [ADC_BITS-1:0]   adiff;
  logic [7:0]            step_inc;
  logic signed [TW-1:0]  s_x;
  logic signed [TW-1:0]  thr_up;
  logic signed [TW-1:0]  thr_dn;
  logic                  fin;
  logic                  fin_ok;

  // Clamp the requested level into the converter range.
  always_comb begin
    treq_x = 18'(target);
    if (treq_x < 18'sd0) begin
      tgt_clamp = '0;
    end else if (treq_x > LVL_MAX) begin
      tgt_clamp = LVL_MAX[ADC_BITS-1:0];
    end else begin
      tgt_clamp = treq_x[ADC_BITS-1:0];
    end
  end

  // Distance to the target and the coarse stop thresholds.
  assign adiff    = (sample > tl_r) ? (sample - tl_r) : (tl_r - sample);
  assign step_inc = step_r + 8'd1;
  assign s_x      = $signed(TW'(sample));
  assign thr_up   = $signed(TW'(tl_r)) - $signed(TW'(cfg.overshoot));
  assign thr_dn   = $signed(TW'(tl_r)) + $signed(TW'(cfg.overshoot));

  // Decision for one word.
  always_comb begin
    phase_nxt = phase_r;
    tl_nxt    = tl_r;
    thr_nxt   = thr_r;
    step_nxt  = step_r;
    ro_nxt    = ro_r;
    drv_nxt   = drv_r;
    res       = '0;
    fin       = 1'b0;
    fin_ok    = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (op == idsc_pkg::OP_WRITE) begin
        tl_nxt    = tgt_clamp;
        ro_nxt    = 1'b0;
        phase_nxt = PH_ENTRY;
        res.busy  = 1'b1;
      end else if (op == idsc_pkg::OP_REFRESH) begin
        ro_nxt    = 1'b1;
        phase_nxt = PH_FINE_START;
        res.busy  = 1'b1;
      end
    end else if (op != idsc_pkg::OP_SAMPLE) begin
      // A command during an operation is ignored.
      res.drive = drv_r;
      res.busy  = 1'b1;
    end else begin
      unique case (phase_r)
        PH_ENTRY: begin
          if (CW'(adiff) > CW'(cfg.overshoot)) begin
            if (cfg.coarse_limit == 8'd0) begin
              fin = 1'b1;
            end else begin
              step_nxt = '0;
              if (sample < tl_r) begin
                thr_nxt   = thr_up;
                phase_nxt = PH_COARSE_UP;
                drv_nxt   = idsc_pkg::DRV_UP;
              end else begin
                thr_nxt   = thr_dn;
                phase_nxt = PH_COARSE_DOWN;
                drv_nxt   = idsc_pkg::DRV_DOWN;
              end
            end
          end else begin
            phase_nxt = PH_FINE_START;
          end
        end
        PH_COARSE_UP, PH_COARSE_DOWN: begin
          if ((phase_r == PH_COARSE_UP && s_x >= thr_r) ||
              (phase_r == PH_COARSE_DOWN && s_x <= thr_r)) begin
            drv_nxt   = idsc_pkg::DRV_HOLD;
            phase_nxt = PH_FINE_START;
          end else begin
            step_nxt = step_inc;
            if (step_inc == 8'd0 || step_inc >= cfg.coarse_limit) begin
              fin = 1'b1;
            end
          end
        end
        PH_FINE_START: begin
          if (sample == tl_r) begin
            if (ro_r) begin
              fin    = 1'b1;
              fin_ok = 1'b1;
            end else begin
              phase_nxt = PH_FINAL;
            end
          end else if (cfg.fine_limit == 8'd0) begin
            fin = 1'b1;
          end else begin
            step_nxt  = '0;
            phase_nxt = (sample < tl_r) ? PH_FINE_UP : PH_FINE_DOWN;
            res.pulse = (sample < tl_r) ? idsc_pkg::PLS_UP : idsc_pkg::PLS_DOWN;
          end
        end
        PH_FINE_UP, PH_FINE_DOWN: begin
          if ((phase_r == PH_FINE_UP && sample >= tl_r) ||
              (phase_r == PH_FINE_DOWN && sample <= tl_r)) begin
            // Target crossed: one correction pulse in the same direction.
            res.pulse = (phase_r == PH_FINE_UP) ? idsc_pkg::PLS_UP : idsc_pkg::PLS_DOWN;
            if (ro_r) begin
              fin    = 1'b1;
              fin_ok = 1'b1;
            end else begin
              phase_nxt = PH_FINAL;
            end
          end else begin
            step_nxt = step_inc;
            if (step_inc == 8'd0 || step_inc >= cfg.fine_limit) begin
              fin = 1'b1;
            end else begin
              res.pulse = (phase_r == PH_FINE_UP) ? idsc_pkg::PLS_UP : idsc_pkg::PLS_DOWN;
            end
          end
        end
        PH_FINAL: begin
          fin    = 1'b1;
          fin_ok = CW'(adiff) <= CW'(cfg.final_tolerance);
        end
        PH_IDLE: ;
      endcase
      if (fin) begin
        phase_nxt   = PH_IDLE;
        drv_nxt     = idsc_pkg::DRV_HOLD;
        res.drive   = idsc_pkg::DRV_HOLD;
        res.busy    = 1'b0;
        res.done    = 1'b1;
        res.success = fin_ok;
      end else begin
        res.drive = drv_nxt;
        res.busy  = 1'b1;
      end
    end
  end

  // Controller state, advanced once per word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tl_r    <= '0;
      thr_r   <= '0;
      step_r  <= '0;
      ro_r    <= 1'b0;
      drv_r   <= idsc_pkg::DRV_HOLD;
    end else if (fire) begin
      phase_r <= phase_nxt;
      tl_r    <= tl_nxt;
      thr_r   <= thr_nxt;
      step_r  <= step_nxt;
      ro_r    <= ro_nxt;
      drv_r   <= drv_nxt;
    end
  end

`ifndef SYNTHESIS
  // The pin is driven up exactly during the upward coarse phase.
  a_drive_up: assert property (@(posedge clk) disable iff (!rst_n)
    (drv_r == idsc_pkg::DRV_UP) == (phase_r == PH_COARSE_UP))
    else $error("drive up does not match coarse up phase");

  // The pin is driven down exactly during the downward coarse phase.
  a_drive_dn: assert property (@(posedge clk) disable iff (!rst_n)
    (drv_r == idsc_pkg::DRV_DOWN) == (phase_r == PH_COARSE_DOWN))
    else $error("drive down does not match coarse down phase");

  // A word that ends an operation leaves the controller idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.done |=> phase_r == PH_IDLE)
    else $error("controller not idle after done");

  // State moves only when a word is processed.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(phase_r) && $stable(step_r))
    else $error("state changed without a word");

  // Success is reported only together with done, and never while busy.
  a_success: assert property (@(posedge clk) disable iff (!rst_n)
    res.success |-> res.done && !res.busy)
    else $error("success outside done");
`endif

endmodule

FILE: src/integrator_dac_settle_controller.sv
// An accepted input word is held in the input register; its result, decided by combinational logic,
// is written to the result register when the pipeline advances. Throughput: one word per cycle while
// the result channel does not stall; a word follows the previous one back to back. A stalled result
// holds the pipeline only when both stages are full.
// Reset (rst_n, synchronous, active low) empties both registers, puts the controller
// in idle with target level zero and restores the register defaults.
module integrator_dac_settle_controller #(
  parameter int unsigned ADC_BITS = idsc_pkg::ADC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_operation,
  input  logic signed [15:0]                in_target,
  input  logic [ADC_BITS-1:0]               in_sample,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_drive,
  output logic [1:0]                        out_pulse,
  output logic                              out_busy_res,
  output logic                              out_done_res,
  output logic                              out_success,
  // Configuration port.
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [idsc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic                  in_valid_r;
  logic [1:0]            in_op_r;
  logic signed [15:0]    in_target_r;
  logic [ADC_BITS-1:0]   in_sample_r;
  logic                  out_valid_r;
  idsc_pkg::res_t        out_res_r;
  idsc_pkg::res_t        res;
  idsc_pkg::cfg_t        cfg;
  logic                  advance;
  logic                  fire;

  // Pipeline moves when the result register is empty or being taken.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign fire     = in_valid_r && advance;

  idsc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  idsc_core #(
    .ADC_BITS (ADC_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .op     (in_op_r),
    .target (in_target_r),
    .sample (in_sample_r),
    .cfg    (cfg),
    .res    (res)
  );

  // Valid flags of the input and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // Payload of the input register.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_op_r     <= in_operation;
      in_target_r <= in_target;
      in_sample_r <= in_sample;
    end
  end

  // Payload of the result register.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_drive    = out_res_r.drive;
  assign out_pulse    = out_res_r.pulse;
  assign out_busy_res = out_res_r.busy;
  assign out_done_res = out_res_r.done;
  assign out_success  = out_res_r.success;

endmodule
